/* rtl/edh_pkg.sv */
// edh_pkg: constants (including the hash multiplier) and types for the edge dedup hash table.
// No dependencies.
`default_nettype none
package edh_pkg;
    localparam int ADDR_BITS_DEF   = 9;
    localparam int VERTEX_BITS_DEF = 16;
    localparam logic [31:0] HASH_MULT = 32'd49157;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [15:0] index;
    } cmd_t;
endpackage
`default_nettype wire

/* rtl/edh_ram.sv */
// edh_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module edh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/edh_front.sv */
// edh_front: accepts items, builds the ordered key, hashes it over two stages.
// Depends on edh_pkg.
`default_nettype none
module edh_front import edh_pkg::*; #(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] vert_a,
    input  wire logic [15:0] vert_b,
    input  wire logic [8:0]  slot_index,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  wire logic        q_ready
);
    // stage 1: key and pre-sum; stage 2: multiply
    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [31:0] s1_sum_reg;
    logic        s2_valid_reg;
    cmd_t        s2_cmd_reg;
    logic [VERTEX_BITS-1:0] a_m, b_m, lo, hi;
    logic [31:0] key;
    logic [31:0] prod;
    logic        adv2, adv1;

    assign a_m = vert_a[VERTEX_BITS-1:0];
    assign b_m = vert_b[VERTEX_BITS-1:0];
    assign lo  = (a_m < b_m) ? a_m : b_m;
    assign hi  = (a_m < b_m) ? b_m : a_m;
    assign key = {16'(lo), 16'(hi)};
    assign prod = s1_sum_reg * HASH_MULT;

    assign adv2 = !s2_valid_reg || q_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign full = !adv1;
    assign q_valid = s2_valid_reg;
    assign q_cmd = s2_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= push;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_cmd_reg.func <= func;
            s1_cmd_reg.key <= key;
            s1_cmd_reg.index <= 16'(slot_index);
            s1_sum_reg <= key + {key[23:0], 8'd0};
        end
        if (adv2)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            if (s1_cmd_reg.func == FUNC_INSERT)
            begin
                s2_cmd_reg.index <= 16'(prod[ADDR_BITS-1:0]);
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/edh_back.sv */
// edh_back: executes clear, insert (linear probe) and read on the table RAM; other codes give a zero result.
// Depends on edh_pkg and edh_ram.
`default_nettype none
module edh_back import edh_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_ready,
    output logic             empty,
    input  wire logic        pop,
    output logic [8:0]       slot,
    output logic             occupied,
    output logic [15:0]      edge_low_vertex,
    output logic [15:0]      edge_high_vertex,
    output logic             was_present,
    output logic             overwrote_full
);
    localparam int DEPTH = 1 << ADDR_BITS;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_WAIT = 3'd1, ST_PROBE = 3'd2,
                           ST_CLEAR = 3'd3, ST_OUT = 3'd4, ST_WAIT_P = 3'd5;

    logic [2:0]           state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;
    logic [ADDR_BITS-1:0] step_reg, step_next;
    logic                 init_reg;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [31:0]          wdata, rdata;
    logic                 ovalid_reg;
    logic [8:0]           oslot_reg;
    logic [31:0]          okey_reg;
    logic                 opres_reg, ofull_reg;
    logic                 load;
    logic [8:0]           ld_slot;
    logic [31:0]          ld_key;
    logic                 ld_pres, ld_full;

    edh_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign q_ready = (state_reg == ST_IDLE) && !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        step_next = step_reg;
        we = 1'b0;
        waddr = pos_reg;
        wdata = cmd_reg.key;
        raddr = pos_reg;
        load = 1'b0;
        ld_slot = 9'(pos_reg);
        ld_key = 32'd0;
        ld_pres = 1'b0;
        ld_full = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                raddr = q_cmd.index[ADDR_BITS-1:0];
                if (q_valid && q_ready)
                begin
                    pos_next = q_cmd.index[ADDR_BITS-1:0];
                    step_next = '0;
                    case (q_cmd.func)
                        FUNC_CLEAR:  state_next = ST_CLEAR;
                        FUNC_INSERT: state_next = ST_PROBE;
                        FUNC_READ:   state_next = ST_WAIT;
                        default:
                        begin
                            load = 1'b1;
                            ld_slot = '0;
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                load = 1'b1;
                ld_key = rdata;
                state_next = ST_IDLE;
            end
            ST_PROBE:
            begin
                // rdata holds slot pos_reg
                if ((&step_reg) || rdata == 32'd0 || rdata == cmd_reg.key)
                begin
                    we = 1'b1;
                    load = 1'b1;
                    ld_key = cmd_reg.key;
                    ld_pres = (rdata != 32'd0) && (rdata == cmd_reg.key);
                    ld_full = (rdata != 32'd0) && (rdata != cmd_reg.key);
                    state_next = ST_OUT;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    step_next = step_reg + 1'b1;
                    raddr = pos_reg + 1'b1;
                    state_next = ST_WAIT_P;
                end
            end
            ST_WAIT_P:
            begin
                state_next = ST_PROBE;
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = step_reg;
                wdata = 32'd0;
                step_next = step_reg + 1'b1;
                if (&step_reg)
                begin
                    // the pass after reset gives no result
                    load = !init_reg;
                    ld_slot = '0;
                    state_next = init_reg ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            step_reg   <= '0;
            init_reg   <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (state_reg == ST_CLEAR && (&step_reg))
            begin
                init_reg <= 1'b0;
            end
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (state_reg == ST_IDLE && q_valid && q_ready)
        begin
            cmd_reg <= q_cmd;
        end
        if (load)
        begin
            oslot_reg <= ld_slot;
            okey_reg  <= ld_key;
            opres_reg <= ld_pres;
            ofull_reg <= ld_full;
        end
    end

    assign empty = !ovalid_reg;
    assign slot = oslot_reg;
    assign occupied = okey_reg != 32'd0;
    assign edge_low_vertex = okey_reg[31:16];
    assign edge_high_vertex = okey_reg[15:0];
    assign was_present = opres_reg;
    assign overwrote_full = ofull_reg;
endmodule
`default_nettype wire

/* rtl/edge_dedup_hash_table_unit.sv */
// Edge dedup hash table: an item passes the key/hash front end, then the back end
// reads the RAM for a read or for each insert probe, or zeroes every slot for a clear;
// one item in the back end at a time, held until its result is popped, so the back end
// takes no new item until the result before it has been popped.
// Reset is asynchronous, active low; after it the table is zeroed in a pass over every
// slot while the back end takes no items. Depends on edh_pkg, edh_front, edh_back.
`default_nettype none
module edge_dedup_hash_table_unit import edh_pkg::*; #(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] vert_a,
    input  wire logic [15:0] vert_b,
    input  wire logic [8:0]  slot_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [8:0]       slot,
    output logic             occupied,
    output logic [15:0]      edge_low_vertex,
    output logic [15:0]      edge_high_vertex,
    output logic             was_present,
    output logic             overwrote_full
);
    // transfer between front (key/hash pipeline) and back (probe engine)
    logic q_valid, q_ready;
    cmd_t q_cmd;

    edh_front #(.ADDR_BITS(ADDR_BITS), .VERTEX_BITS(VERTEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .vert_a(vert_a), .vert_b(vert_b), .slot_index(slot_index),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_ready(q_ready)
    );

    edh_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_ready(q_ready), .empty(empty), .pop(pop), .slot(slot),
        .occupied(occupied), .edge_low_vertex(edge_low_vertex),
        .edge_high_vertex(edge_high_vertex), .was_present(was_present),
        .overwrote_full(overwrote_full)
    );
endmodule
`default_nettype wire

/* rtl/edh_checker.sv */
// edh_checker: port-level assertions for edge_dedup_hash_table_unit.
// Bound to the top level; no other dependencies.
`default_nettype none
module edh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [8:0]  slot,
    input wire logic        occupied,
    input wire logic        was_present,
    input wire logic        overwrote_full
);
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(was_present && overwrote_full)) else $error("both flags");
    a_pres: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && was_present) |-> occupied) else $error("present not occupied");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(slot))) else $error("result lost");
endmodule

bind edge_dedup_hash_table_unit edh_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .slot(slot),
    .occupied(occupied), .was_present(was_present), .overwrote_full(overwrote_full)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for edge_dedup_hash_table_unit.
// Holds a scoreboard class with its own edge set, plus queue-style drivers.
// Depends on edh_pkg and edge_dedup_hash_table_unit.
`timescale 1ns / 100ps
module tb_top;
    import edh_pkg::*;

    localparam int SLOTS = 512;
    localparam int SLOT_MASK = SLOTS - 1;

    // one result transfer, field by field
    typedef struct {
        logic [8:0]  slot;
        logic        occupied;
        logic [15:0] lo_vert;
        logic [15:0] hi_vert;
        logic        was_present;
        logic        overwrote_full;
    } edge_result_t;

    // Scoreboard: mirrors the edge set and keeps the expected results in order.
    class edge_set_scoreboard;
        bit [31:0] edge_keys [SLOTS];
        edge_result_t pending_results [$];
        int errors = 0;

        function bit [31:0] hash_of(bit [31:0] v);
            bit [31:0] t;
            t = v + (v << 8);
            return t * 32'd49157;
        endfunction

        function edge_result_t make_result(bit [8:0] pos, bit [31:0] key, bit pres, bit ovf);
            edge_result_t r;
            r.slot = pos;
            r.occupied = (key != 0);
            r.lo_vert = key[31:16];
            r.hi_vert = key[15:0];
            r.was_present = pres;
            r.overwrote_full = ovf;
            return r;
        endfunction

        // accepted input transfer: update the mirror and queue the expectation
        function void note_input(bit [1:0] f, bit [15:0] a, bit [15:0] b, bit [8:0] idx);
            bit [31:0] key;
            bit [31:0] base;
            bit [31:0] old;
            int step;
            bit [8:0] pos;
            if (f == FUNC_CLEAR) begin
                foreach (edge_keys[i]) edge_keys[i] = '0;
                pending_results.push_back(make_result('0, '0, 1'b0, 1'b0));
            end else if (f == FUNC_INSERT) begin
                key = (a < b) ? {a, b} : {b, a};
                base = hash_of(key);
                step = 0;
                pos = base[8:0];
                // probe until free slot, same key, or the last offset
                while (step < SLOT_MASK && edge_keys[pos] != 0 && edge_keys[pos] != key) begin
                    step++;
                    pos = base[8:0] + step[8:0];
                end
                old = edge_keys[pos];
                edge_keys[pos] = key;
                pending_results.push_back(make_result(pos, key, old != 0 && old == key,
                                                      old != 0 && old != key));
            end else if (f == FUNC_READ) begin
                pending_results.push_back(make_result(idx, edge_keys[idx], 1'b0, 1'b0));
            end else begin
                // unused code: no change, all-zero result
                pending_results.push_back(make_result('0, '0, 1'b0, 1'b0));
            end
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(edge_result_t got);
            edge_result_t want;
            if (pending_results.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            if (got.slot !== want.slot)
                report($sformatf("slot got %0d want %0d", got.slot, want.slot));
            if (got.occupied !== want.occupied)
                report($sformatf("occupied got %0b want %0b", got.occupied, want.occupied));
            if (got.lo_vert !== want.lo_vert)
                report($sformatf("low vertex got %h want %h", got.lo_vert, want.lo_vert));
            if (got.hi_vert !== want.hi_vert)
                report($sformatf("high vertex got %h want %h", got.hi_vert, want.hi_vert));
            if (got.was_present !== want.was_present)
                report($sformatf("was_present got %0b want %0b",
                                 got.was_present, want.was_present));
            if (got.overwrote_full !== want.overwrote_full)
                report($sformatf("overwrote_full got %0b want %0b",
                                 got.overwrote_full, want.overwrote_full));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  func;
    logic [15:0] vert_a;
    logic [15:0] vert_b;
    logic [8:0]  slot_index;
    logic        empty;
    logic        pop;
    logic [8:0]  slot;
    logic        occupied;
    logic [15:0] edge_low_vertex;
    logic [15:0] edge_high_vertex;
    logic        was_present;
    logic        overwrote_full;

    edge_set_scoreboard edge_sb;
    int  rx_hold_cycles = 0;   // receiver stall request, consumed by the receiver
    bit  rx_quiet = 0;         // receiver draws no gaps while set

    edge_dedup_hash_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .func(func), .vert_a(vert_a), .vert_b(vert_b), .slot_index(slot_index),
        .empty(empty), .pop(pop),
        .slot(slot), .occupied(occupied),
        .edge_low_vertex(edge_low_vertex), .edge_high_vertex(edge_high_vertex),
        .was_present(was_present), .overwrote_full(overwrote_full)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: far above the slowest legal run (full-table probing dominates).
    initial
    begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One input transfer: optional idle gap, then hold push until accepted.
    // push is lowered only for a requested gap, so it never toggles within a step.
    task automatic send_item(bit [1:0] f, bit [15:0] a, bit [15:0] b, bit [8:0] idx,
                             int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        func <= f;
        vert_a <= a;
        vert_b <= b;
        slot_index <= idx;
        do @(posedge clk); while (full);
        edge_sb.note_input(f, a, b, idx);
    endtask

    task automatic send_rand_gap(bit [1:0] f, bit [15:0] a, bit [15:0] b, bit [8:0] idx);
        int gap;
        // about a third of items go back to back
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        send_item(f, a, b, idx, gap);
    endtask

    // sender goes idle, then waits for every expected result
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (edge_sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // random item: mostly inserts over a small vertex pool so duplicates happen
    task automatic send_random();
        int sel;
        bit [15:0] a;
        bit [15:0] b;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
        end
        else
        begin
            a = 16'($urandom_range(0, 12));
            b = 16'($urandom_range(0, 12));
        end
        if (sel < 3)
            send_rand_gap(FUNC_CLEAR, 16'($urandom), 16'($urandom), 9'($urandom));
        else if (sel < 5)
            send_rand_gap(2'd3, 16'($urandom), 16'($urandom), 9'($urandom));
        else if (sel < 70)
            send_rand_gap(FUNC_INSERT, a, b, 9'($urandom));
        else
            send_rand_gap(FUNC_READ, 16'($urandom), 16'($urandom),
                          9'($urandom_range(0, SLOT_MASK)));
    endtask

    // receiver: random pop gaps, plus long hold-offs on request
    initial
    begin
        edge_result_t got;
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                gap = rx_quiet ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19));
                if (gap > 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.slot = slot;
            got.occupied = occupied;
            got.lo_vert = edge_low_vertex;
            got.hi_vert = edge_high_vertex;
            got.was_present = was_present;
            got.overwrote_full = overwrote_full;
            edge_sb.check_result(got);
        end
    end

    // main stimulus
    initial
    begin
        edge_sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        func = FUNC_CLEAR;
        vert_a = '0;
        vert_b = '0;
        slot_index = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // clear on a freshly reset table, offered while the reset pass runs
        send_item(FUNC_CLEAR, 16'h0, 16'h0, 9'h0, 0);
        // directed: extremes, swap order, duplicate, zero edge, all ops
        send_item(FUNC_INSERT, 16'h0000, 16'hFFFF, 9'h0, 0);
        send_item(FUNC_INSERT, 16'hFFFF, 16'h0000, 9'h0, 3);
        send_item(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 9'h1FF, 0);
        send_item(FUNC_INSERT, 16'h1234, 16'h0005, 9'h0, 1);
        send_item(FUNC_INSERT, 16'h0005, 16'h1234, 9'h0, 0);
        send_item(FUNC_INSERT, 16'h0000, 16'h0000, 9'h0, 0);
        send_item(FUNC_INSERT, 16'h0001, 16'h0001, 9'h0, 2);
        send_item(FUNC_READ, 16'hFFFF, 16'hFFFF, 9'h000, 0);
        send_item(FUNC_READ, 16'h0, 16'h0, 9'h1FF, 0);
        send_item(FUNC_READ, 16'h0, 16'h0, 9'h155, 5);
        send_item(FUNC_READ, 16'h0, 16'h0, 9'h0AA, 0);
        send_item(2'd3, 16'hFFFF, 16'hFFFF, 9'h1FF, 0);
        send_item(FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 9'h1FF, 0);
        send_item(FUNC_READ, 16'h0, 16'h0, 9'h1FF, 0);
        wait_drained();

        // pressure: receiver stalls while the sender keeps offering
        rx_hold_cycles = 400;
        repeat (40) send_item(FUNC_INSERT, 16'($urandom_range(0, 9)),
                              16'($urandom_range(0, 9)), 9'h0, 0);
        wait_drained();

        // fill the table with distinct keys, then exercise the full-table path
        rx_quiet = 1;
        for (int i = 0; i < SLOTS; i++)
            send_item(FUNC_INSERT, i[15:0] + 16'd1, 16'd40000 + i[15:0], 9'h0, 0);
        send_item(FUNC_INSERT, 16'h0003, 16'd40002, 9'h0, 0);   // already there
        send_item(FUNC_INSERT, 16'h7777, 16'h8888, 9'h0, 0);    // no free slot
        send_item(FUNC_INSERT, 16'hAAAA, 16'h5555, 9'h0, 0);    // no free slot
        send_item(FUNC_INSERT, 16'h0000, 16'h0000, 9'h0, 0);    // zero key in full table
        for (int i = 0; i < 8; i++)
            send_item(FUNC_READ, 16'h0, 16'h0, 9'($urandom_range(0, SLOT_MASK)), 0);
        rx_quiet = 0;
        wait_drained();
        send_item(FUNC_CLEAR, 16'h0, 16'h0, 9'h0, 0);

        // random body, with one more receiver stall midway
        for (int n = 0; n < 435; n++)
        begin
            if (n == 200)
                rx_hold_cycles = 300;
            send_random();
        end

        wait_drained();
        for (int n = 0; n < 435; n++)
            send_random();

        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);
        if (edge_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
